// ----- hw/rtl/rad_pkg.sv -----
// Shared types, constants and helper functions of the range alarm debouncer.
// Used by rad_cfg, rad_eval and range_alarm_debouncer; depends on nothing.
package rad_pkg;

	// Widths of the item fields
	localparam int TEMP_W  = 12;
	localparam int PH_W    = 11;
	localparam int LEVEL_W = 12;
	localparam int CNT_W   = 7;
	localparam int CMP_W   = 14;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_TEMP_HI  = 3'd0;
	localparam logic [2:0] REG_TEMP_LO  = 3'd1;
	localparam logic [2:0] REG_PH_HI    = 3'd2;
	localparam logic [2:0] REG_PH_LO    = 3'd3;
	localparam logic [2:0] REG_LEVEL_HI = 3'd4;
	localparam logic [2:0] REG_LEVEL_LO = 3'd5;
	localparam logic [2:0] REG_EMPTY    = 3'd6;

	// Request kinds
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_LINK   = 1'b1;

	// Alarm codes
	localparam logic [1:0] ALM_NONE = 2'd0;
	localparam logic [1:0] ALM_HIGH = 2'd1;
	localparam logic [1:0] ALM_LOW  = 2'd2;
	localparam logic [1:0] ALM_FAR  = 2'd3;

	// Counter limits
	localparam logic [CNT_W-1:0] STRIKE_WRAP_TOP = 7'd124;
	localparam logic [CNT_W-1:0] STRIKE_ALARM    = 7'd5;
	localparam logic [CNT_W-1:0] STRIKE_CUT      = 7'd3;
	localparam logic [CNT_W-1:0] STRIKE_KEEP     = 7'd2;
	localparam logic [CNT_W-1:0] HEALTH_TOP      = 7'd125;
	localparam logic [CNT_W-1:0] HEALTH_RESTART  = 7'd5;

	// Classification margins
	localparam logic signed [CMP_W-1:0] TEMP_MARGIN = 14'sd100;
	localparam logic signed [CMP_W-1:0] PH_MARGIN   = 14'sd100;
	localparam logic signed [CMP_W-1:0] LEVEL_EDGE  = 14'sd10;

	typedef logic signed [CMP_W-1:0] cmp_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_hi;
		logic signed [TEMP_W-1:0] temp_lo;
		logic [PH_W-1:0]          ph_hi;
		logic [PH_W-1:0]          ph_lo;
		logic [LEVEL_W-1:0]       level_hi;
		logic [LEVEL_W-1:0]       level_lo;
		logic [LEVEL_W-1:0]       empty;
	} cfg_t;

	typedef struct packed {
		logic                     req_type;
		logic signed [TEMP_W-1:0] temperature;
		logic [PH_W-1:0]          ph_value;
		logic [LEVEL_W-1:0]       level_distance;
	} item_t;

	typedef struct packed {
		logic [1:0]       temp_alarm;
		logic [1:0]       ph_alarm;
		logic [1:0]       level_alarm;
		logic             health_beat;
		logic [CNT_W-1:0] health_count;
		logic             link_alarm;
	} res_t;

	// Strike counter step: count up with wrap, or cut down and decay
	function automatic logic [CNT_W-1:0] strike_next(logic [CNT_W-1:0] cnt, logic oor);
		logic [CNT_W-1:0] nxt;
		if (oor) begin
			nxt = cnt + 7'd1;
			if (nxt > STRIKE_WRAP_TOP) nxt = STRIKE_ALARM;
		end else begin
			nxt = (cnt > STRIKE_CUT) ? STRIKE_KEEP : cnt;
			if (nxt != '0) nxt = nxt - 7'd1;
		end
		return nxt;
	endfunction

	// Window class of an out-of-range value; high side checked first
	function automatic logic [1:0] window_class(cmp_t v, cmp_t lo, cmp_t hi, cmp_t margin);
		cmp_t d_hi;
		cmp_t d_lo;
		d_hi = v - hi;
		d_lo = v - lo;
		if (v > hi && d_hi < margin) return ALM_HIGH;
		else if (v < lo && d_lo > -margin) return ALM_LOW;
		else return ALM_FAR;
	endfunction

endpackage

// ----- hw/rtl/rad_cfg.sv -----
// Configuration register file of the range alarm debouncer.
// Depends on rad_pkg for the register indexes and the cfg_t struct.
module rad_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [11:0]          cfg_wdata,
	output rad_pkg::cfg_t        cfg
);
	import rad_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_hi  <= 12'sd280;
			cfg_q.temp_lo  <= 12'sd220;
			cfg_q.ph_hi    <= 11'd750;
			cfg_q.ph_lo    <= 11'd650;
			cfg_q.level_hi <= 12'd200;
			cfg_q.level_lo <= 12'd100;
			cfg_q.empty    <= 12'd400;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TEMP_HI:  cfg_q.temp_hi  <= $signed(cfg_wdata);
				REG_TEMP_LO:  cfg_q.temp_lo  <= $signed(cfg_wdata);
				REG_PH_HI:    cfg_q.ph_hi    <= cfg_wdata[PH_W-1:0];
				REG_PH_LO:    cfg_q.ph_lo    <= cfg_wdata[PH_W-1:0];
				REG_LEVEL_HI: cfg_q.level_hi <= cfg_wdata;
				REG_LEVEL_LO: cfg_q.level_lo <= cfg_wdata;
				REG_EMPTY:    cfg_q.empty    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/rad_eval.sv -----
// Per-item evaluation: range checks, strike and health counters, alarm codes.
// Depends on rad_pkg for types, constants and the counter/class functions.
module rad_eval (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  rad_pkg::item_t item,
	input  rad_pkg::cfg_t  cfg,
	output rad_pkg::res_t  res
);
	import rad_pkg::*;

	logic [CNT_W-1:0] temp_strikes_q, ph_strikes_q, level_strikes_q, health_q;
	logic [CNT_W-1:0] temp_nxt, ph_nxt, level_nxt, health_inc, health_nxt;
	cmp_t t_v, t_hi, t_lo, p_v, p_hi, p_lo, l_v, l_hi, l_lo, l_empty;
	logic t_oor, p_oor, l_oor, is_link, beat;
	logic [1:0] t_alm, p_alm, l_alm;

	// Widen everything to one signed compare width
	assign t_v     = {{(CMP_W-TEMP_W){item.temperature[TEMP_W-1]}}, item.temperature};
	assign t_hi    = {{(CMP_W-TEMP_W){cfg.temp_hi[TEMP_W-1]}}, cfg.temp_hi};
	assign t_lo    = {{(CMP_W-TEMP_W){cfg.temp_lo[TEMP_W-1]}}, cfg.temp_lo};
	assign p_v     = {{(CMP_W-PH_W){1'b0}}, item.ph_value};
	assign p_hi    = {{(CMP_W-PH_W){1'b0}}, cfg.ph_hi};
	assign p_lo    = {{(CMP_W-PH_W){1'b0}}, cfg.ph_lo};
	assign l_v     = {{(CMP_W-LEVEL_W){1'b0}}, item.level_distance};
	assign l_hi    = {{(CMP_W-LEVEL_W){1'b0}}, cfg.level_hi};
	assign l_lo    = {{(CMP_W-LEVEL_W){1'b0}}, cfg.level_lo};
	assign l_empty = {{(CMP_W-LEVEL_W){1'b0}}, cfg.empty};

	assign is_link = (item.req_type == REQ_LINK);

	// Out-of-window tests
	assign t_oor = (t_v > t_hi) || (t_v < t_lo);
	assign p_oor = (p_v > p_hi) || (p_v < p_lo);
	assign l_oor = (l_v > l_hi) || (l_v < l_lo);

	// Counter steps
	assign temp_nxt  = strike_next(temp_strikes_q, t_oor);
	assign ph_nxt    = strike_next(ph_strikes_q, p_oor);
	assign level_nxt = strike_next(level_strikes_q, l_oor);

	// Alarm classification, only at the strike that hits the alarm point
	always_comb begin
		t_alm = ALM_NONE;
		p_alm = ALM_NONE;
		l_alm = ALM_NONE;
		if (t_oor && temp_nxt == STRIKE_ALARM)
			t_alm = window_class(t_v, t_lo, t_hi, TEMP_MARGIN);
		if (p_oor && ph_nxt == STRIKE_ALARM)
			p_alm = window_class(p_v, p_lo, p_hi, PH_MARGIN);
		if (l_oor && level_nxt == STRIKE_ALARM) begin
			priority if (l_v > l_hi && l_v < l_empty - LEVEL_EDGE) l_alm = ALM_HIGH;
			else if (l_v < l_lo && l_v > LEVEL_EDGE) l_alm = ALM_LOW;
			else l_alm = ALM_FAR;
		end
	end

	// Health counter: cleared on a link item or while any strike count is above STRIKE_KEEP
	assign health_inc = health_q + 7'd1;
	always_comb begin
		beat = 1'b0;
		if (is_link) begin
			health_nxt = '0;
		end else if (temp_nxt > STRIKE_KEEP || ph_nxt > STRIKE_KEEP ||
				level_nxt > STRIKE_KEEP) begin
			health_nxt = '0;
		end else if (health_inc > HEALTH_TOP) begin
			health_nxt = HEALTH_RESTART;
			beat       = 1'b1;
		end else begin
			health_nxt = health_inc;
		end
	end

	// State update when the item moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_strikes_q  <= '0;
			ph_strikes_q    <= '0;
			level_strikes_q <= '0;
			health_q        <= HEALTH_RESTART;
		end else if (en) begin
			health_q <= health_nxt;
			if (!is_link) begin
				temp_strikes_q  <= temp_nxt;
				ph_strikes_q    <= ph_nxt;
				level_strikes_q <= level_nxt;
			end
		end
	end

	// Result item; link fault reports nothing but the link flag
	always_comb begin
		res.temp_alarm   = is_link ? ALM_NONE : t_alm;
		res.ph_alarm     = is_link ? ALM_NONE : p_alm;
		res.level_alarm  = is_link ? ALM_NONE : l_alm;
		res.health_beat  = beat;
		res.health_count = health_nxt;
		res.link_alarm   = is_link;
	end

endmodule

// ----- hw/rtl/range_alarm_debouncer.sv -----
// Range alarm debouncer, top level: input register, evaluation, result register.
// An accepted item goes through the input register, then the result register; a low m_tready can stall it.
// Throughput one item per cycle; s_tready drops only while both registers are full and m_tready is low.
// Reset (arst_n low, asynchronous): pipeline empty, strike counters 0, health 5,
// limits back to their default values.
// Depends on rad_pkg, rad_cfg and rad_eval.
module range_alarm_debouncer (
	input  logic        clk,
	input  logic        arst_n,
	// Sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // temperature[11:0], ph_value[22:12], level_distance[34:23]
	input  logic        s_tuser,   // req_type
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // temp_alarm[1:0], ph_alarm[3:2], level_alarm[5:4],
	                               // health_beat[6], health_count[13:7]
	output logic        m_tuser,   // link_alarm
	// Configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [11:0] cfg_wdata
);
	import rad_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv_s1;

	rad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake: stage 1 moves on when the result register is free or drains
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type       <= s_tuser;
			item_s1.temperature    <= $signed(s_tdata[11:0]);
			item_s1.ph_value       <= s_tdata[22:12];
			item_s1.level_distance <= s_tdata[34:23];
		end
	end

	rad_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.health_count, res_s2.health_beat,
		res_s2.level_alarm, res_s2.ph_alarm, res_s2.temp_alarm};
	assign m_tuser  = res_s2.link_alarm;

endmodule
